FILE: src/dgd_pkg.sv
// shared types, constants and helper functions of the dtmf goertzel decoder
// no dependencies; imported by every module of the block
package dgd_pkg;

    localparam int NUM_FILT = 8;
    localparam int ADDR_W   = 3;
    localparam int Q_W      = 32;
    localparam int ENTRY_W  = 2 * Q_W;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;
    localparam int QUIET_W  = 24;
    localparam int POWER_W  = 62;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W    = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER = 1'd1;

    // register reset values
    localparam logic [QUIET_W-1:0] QUIET_RST = 24'd49152;
    localparam logic [POWER_W-1:0] POWER_RST = 62'd134217728000;
    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};

    // result status codes
    localparam logic [1:0] STATUS_NONE  = 2'd0;
    localparam logic [1:0] STATUS_KEY   = 2'd1;
    localparam logic [1:0] STATUS_MULTI = 2'd2;

    // half-lsb rounding offset for the q2.14 coefficient product
    localparam logic signed [47:0] RND_HALF = 48'sd8192;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_UPD  = 5'b00100,
        S_PWR  = 5'b01000,
        S_DEC  = 5'b10000
    } t_state;

    // write port of the filter state memory
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } t_mem_wr;

    // tag that follows a memory read, registered so that it lines up with the read data
    typedef struct packed {
        logic              upd;
        logic              pwr;
        logic [ADDR_W-1:0] addr;
    } t_rd_tag;

    // per filter threshold result
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] idx;
        logic              hit;
    } t_hit;

    // 2*cos(w) in q2.14: rows 0..3, then columns 0..3
    function automatic logic signed [15:0] coef(input logic [ADDR_W-1:0] k);
        logic signed [15:0] c;
        case (k)
            3'd0:    c = 16'sd27980;
            3'd1:    c = 16'sd26956;
            3'd2:    c = 16'sd25701;
            3'd3:    c = 16'sd24219;
            3'd4:    c = 16'sd19073;
            3'd5:    c = 16'sd16325;
            3'd6:    c = 16'sd13085;
            3'd7:    c = 16'sd9315;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] popcnt4(input logic [3:0] v);
        return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
    endfunction

    // index of the highest set bit of a four bit group
    function automatic logic [1:0] idx4(input logic [3:0] v);
        logic [1:0] r;
        r = 2'd0;
        if (v[1]) r = 2'd1;
        if (v[2]) r = 2'd2;
        if (v[3]) r = 2'd3;
        return r;
    endfunction

endpackage

FILE: src/dgd_state_ram.sv
// filter state memory: eight entries of {prev, prev2}
// one write and one registered read port; uses dgd_pkg
module dgd_state_ram
    import dgd_pkg::*;
(
    input  logic                i_clk,
    input  t_mem_wr             i_wr,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output logic [ENTRY_W-1:0]  o_rd_data
);

    logic [ENTRY_W-1:0] r_mem [NUM_FILT];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/dgd_update_unit.sv
// goertzel recurrence for one filter per cycle: q0 = x + round(c*q1) - q2
// two stages from memory read data to write-back; uses dgd_pkg
module dgd_update_unit
    import dgd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_vld,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    input  logic [ENTRY_W-1:0]         i_rd_data,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output t_mem_wr                    o_wr
);

    logic signed [Q_W-1:0] q1_in;
    logic signed [47:0]    n_prod;

    logic                  r_vld;
    logic [ADDR_W-1:0]     r_addr;
    logic signed [47:0]    r_prod;
    logic signed [Q_W-1:0] r_q1;
    logic signed [Q_W-1:0] r_q2;

    logic signed [47:0]    rnd;
    logic signed [33:0]    sc;
    logic signed [35:0]    q0_wide;
    logic signed [Q_W-1:0] q0;

    // stage a: coefficient product
    assign q1_in  = $signed(i_rd_data[ENTRY_W-1:Q_W]);
    assign n_prod = coef(i_rd_addr) * q1_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= i_rd_addr;
        r_prod <= n_prod;
        r_q1   <= q1_in;
        r_q2   <= $signed(i_rd_data[Q_W-1:0]);
    end

    // stage b: round, sum, saturate
    always_comb begin
        rnd     = r_prod + RND_HALF;
        sc      = rnd[47:14];
        q0_wide = 36'(i_sample) + 36'(sc) - 36'(r_q2);
        if (q0_wide[35:31] == 5'b00000 || q0_wide[35:31] == 5'b11111) begin
            q0 = q0_wide[Q_W-1:0];
        end else if (q0_wide[35]) begin
            q0 = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            q0 = {1'b0, {(Q_W-1){1'b1}}};
        end
    end

    assign o_wr.en   = r_vld;
    assign o_wr.addr = r_addr;
    assign o_wr.data = {q0, r_q1};

endmodule

FILE: src/dgd_power_unit.sv
// goertzel power q1^2 + q2^2 - q2*round(c*q1), clamped, against the threshold
// three stages, one filter per cycle; uses dgd_pkg
module dgd_power_unit
    import dgd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_vld,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    input  logic [ENTRY_W-1:0]   i_rd_data,
    input  logic [POWER_W-1:0]   i_power_thr,
    output t_hit                 o_hit
);

    logic signed [Q_W-1:0] q1_in;
    logic signed [Q_W-1:0] q2_in;
    logic signed [47:0]    n1_prod;
    logic signed [63:0]    n1_sq1;
    logic signed [63:0]    n1_sq2;

    logic                  r1_vld;
    logic [ADDR_W-1:0]     r1_idx;
    logic signed [47:0]    r1_prod;
    logic [62:0]           r1_sq1;
    logic [62:0]           r1_sq2;
    logic signed [Q_W-1:0] r1_q2;

    logic signed [47:0]    rnd;
    logic signed [33:0]    sc;
    logic signed [65:0]    n2_p;

    logic                  r2_vld;
    logic [ADDR_W-1:0]     r2_idx;
    logic signed [63:0]    r2_p;
    logic [63:0]           r2_s;

    logic signed [65:0]    diff;
    logic [POWER_W-1:0]    pwr;

    // stage 1: squares and coefficient product
    assign q1_in   = $signed(i_rd_data[ENTRY_W-1:Q_W]);
    assign q2_in   = $signed(i_rd_data[Q_W-1:0]);
    assign n1_prod = coef(i_rd_addr) * q1_in;
    assign n1_sq1  = q1_in * q1_in;
    assign n1_sq2  = q2_in * q2_in;

    // stage 2: cross term and sum of squares
    assign rnd  = r1_prod + RND_HALF;
    assign sc   = rnd[47:14];
    assign n2_p = sc * r1_q2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_rd_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_idx  <= i_rd_addr;
        r1_prod <= n1_prod;
        r1_sq1  <= n1_sq1[62:0];
        r1_sq2  <= n1_sq2[62:0];
        r1_q2   <= q2_in;
        r2_idx  <= r1_idx;
        r2_p    <= n2_p[63:0];
        r2_s    <= {1'b0, r1_sq1} + {1'b0, r1_sq2};
    end

    // stage 3: difference, clamp to [0, 2^62-1], compare
    always_comb begin
        diff = $signed({2'b00, r2_s}) - 66'(r2_p);
        if (diff[65]) begin
            pwr = '0;
        end else if (diff[64:62] != 3'b000) begin
            pwr = POWER_MAX;
        end else begin
            pwr = diff[POWER_W-1:0];
        end
    end

    assign o_hit.vld = r2_vld;
    assign o_hit.idx = r2_idx;
    assign o_hit.hit = pwr > i_power_thr;

endmodule

FILE: src/dtmf_goertzel_decoder_unit.sv
// top level of the dtmf goertzel decoder: sequencer, sum, decision, output register
// depends on dgd_pkg, dgd_state_ram, dgd_update_unit, dgd_power_unit
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  --------------------------------
//  input     in         i_valid / o_stall    i_sample[15:0], i_last_sample
//  result    out        o_valid / i_stall    o_key_index[3:0], o_status[1:0]
//  config    in         i_cfg_we             i_cfg_index[0:0], i_cfg_data[61:0]
//
// a sample that is not flagged last runs the S_UPD pass: the eight filter
// entries are read one per cycle from the state memory and written back
// through the registers of the shared update datapath
// a last sample then runs a second pass over the memory that feeds the
// power pipeline and zeroes each entry, then a decision in S_DEC
// after reset a clearing pass zeroes the state memory; config writes are taken
// a pending result waits in the output register while the next frame starts;
// only the decision cycle of the next frame waits for the register to empty
module dtmf_goertzel_decoder_unit
    import dgd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last_sample,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [3:0]                 o_key_index,
    output logic [1:0]                 o_status,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [POWER_W-1:0]         i_cfg_data
);

    // sequencer
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // thresholds
    logic [QUIET_W-1:0] r_quiet_thr;
    logic [POWER_W-1:0] r_power_thr;

    // current item and frame sum
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_last;
    logic [SUM_W-1:0]           r_abs_sum, n_abs_sum;
    logic [SAMPLE_W:0]          mag;
    logic [SUM_W:0]             sum_wide;

    // memory interface
    logic               rd_en;
    t_rd_tag            r_rtag, n_rtag;
    logic [ENTRY_W-1:0] rd_data;
    t_mem_wr            upd_wr;
    t_mem_wr            mem_wr;
    t_hit               hit;
    logic [NUM_FILT-1:0] r_hits;

    // decision and output register
    logic               r_ovalid, n_ovalid;
    logic [3:0]         r_key, n_key;
    logic [1:0]         r_status, n_status;
    logic               in_acc;
    logic               out_acc;
    logic               out_free;
    logic [3:0]         rows;
    logic [3:0]         cols;
    logic [2:0]         nrows;
    logic [2:0]         ncols;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_ovalid && !i_stall;
    assign out_free = !r_ovalid || !i_stall;

    // saturating absolute sum
    always_comb begin
        mag      = i_sample[SAMPLE_W-1] ? 17'(-17'(i_sample)) : 17'(i_sample);
        sum_wide = {1'b0, r_abs_sum} + 25'(mag);
        if (sum_wide[SUM_W]) begin
            n_abs_sum = {SUM_W{1'b1}};
        end else begin
            n_abs_sum = sum_wide[SUM_W-1:0];
        end
    end

    // decision from the row and column hits
    assign rows  = r_hits[3:0];
    assign cols  = r_hits[7:4];
    assign nrows = popcnt4(rows);
    assign ncols = popcnt4(cols);

    always_comb begin
        n_key    = 4'd0;
        n_status = STATUS_NONE;
        if (r_abs_sum >= r_quiet_thr) begin
            if (nrows >= 3'd2 || ncols >= 3'd2) begin
                n_status = STATUS_MULTI;
            end else if (nrows == 3'd1 && ncols == 3'd1) begin
                n_status = STATUS_KEY;
                n_key    = {idx4(rows), idx4(cols)};
            end
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        rd_en    = 1'b0;
        n_ovalid = r_ovalid && !out_acc;
        case (r_state)
            S_CLR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_FILT - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end
            end
            S_IDLE: begin
                n_cnt = '0;
                if (in_acc) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // reads while r_cnt is 0..7; the state holds until the last write-back has landed
                rd_en = !r_cnt[CNT_W-1];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_FILT + 1)) begin
                    n_state = r_last ? S_PWR : S_IDLE;
                    n_cnt   = '0;
                end
            end
            S_PWR: begin
                // reads while r_cnt is 0..7; the state holds until the last hit is registered
                rd_en = !r_cnt[CNT_W-1];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_FILT + 2)) begin
                    n_state = S_DEC;
                    n_cnt   = '0;
                end
            end
            S_DEC: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    assign n_rtag.upd  = rd_en && (r_state == S_UPD);
    assign n_rtag.pwr  = rd_en && (r_state == S_PWR);
    assign n_rtag.addr = r_cnt[ADDR_W-1:0];

    // write port: reset clearing, recurrence write-back, or zeroing behind the power pass
    always_comb begin
        mem_wr = upd_wr;
        if (r_state == S_CLR) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = r_cnt[ADDR_W-1:0];
            mem_wr.data = '0;
        end else if (r_rtag.pwr) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = r_rtag.addr;
            mem_wr.data = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_rtag      <= '0;
            r_ovalid    <= 1'b0;
            r_abs_sum   <= '0;
            r_quiet_thr <= QUIET_RST;
            r_power_thr <= POWER_RST;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rtag   <= n_rtag;
            r_ovalid <= n_ovalid;
            if (in_acc) begin
                r_abs_sum <= n_abs_sum;
            end else if (r_state == S_DEC && out_free) begin
                r_abs_sum <= '0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_QUIET: begin
                        r_quiet_thr <= i_cfg_data[QUIET_W-1:0];
                    end
                    CFG_POWER: begin
                        r_power_thr <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_sample;
            r_last   <= i_last_sample;
        end
        if (hit.vld) begin
            r_hits[hit.idx] <= hit.hit;
        end
        if (r_state == S_DEC && out_free) begin
            r_key    <= n_key;
            r_status <= n_status;
        end
    end

    dgd_state_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_cnt[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    dgd_update_unit u_upd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_vld  (r_rtag.upd),
        .i_rd_addr (r_rtag.addr),
        .i_rd_data (rd_data),
        .i_sample  (r_sample),
        .o_wr      (upd_wr)
    );

    dgd_power_unit u_pwr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_vld    (r_rtag.pwr),
        .i_rd_addr   (r_rtag.addr),
        .i_rd_data   (rd_data),
        .i_power_thr (r_power_thr),
        .o_hit       (hit)
    );

    assign o_valid     = r_ovalid;
    assign o_key_index = r_key;
    assign o_status    = r_status;

endmodule
